// ===== sv/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: shared definitions for the log record checker
// Phase codes, field widths, the result bundle and the byte-wise CRC-32.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

  localparam int OFFSET_BITS = 48;

  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Record header overhead: checksum, key length, value length
  localparam logic [OFFSET_BITS:0] HDR_BYTES = (OFFSET_BITS+1)'(12);

  // Parser phases
  localparam logic [2:0] PH_CRC  = 3'd0;
  localparam logic [2:0] PH_KLEN = 3'd1;
  localparam logic [2:0] PH_KEY  = 3'd2;
  localparam logic [2:0] PH_VLEN = 3'd3;
  localparam logic [2:0] PH_VAL  = 3'd4;
  localparam logic [2:0] PH_HALT = 3'd5;

  // Payload tags
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // Commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic [1:0]             payload_kind;
    logic [7:0]             payload_byte;
    logic                   record_end;
    logic                   record_ok;
    logic [31:0]            key_length;
    logic [31:0]            value_length;
    logic                   halted;
    logic                   log_end;
    logic                   truncated;
    logic [OFFSET_BITS-1:0] valid_offset;
  } lrc_result_t;

  // Reflected CRC-32 over one byte, one bit per step
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lrc_parser.sv =====
// ----------------------------------------------------------------------------
// lrc_parser: record framing state and per-byte result
// Holds the parse state, advances it on each transfer and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_parser
  import lrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        cmd,
  input  wire logic [7:0]  data_byte,
  output lrc_result_t      result
);

  logic [2:0]             phase_r,        phase_nxt;
  logic [1:0]             idx_r,          idx_nxt;
  logic [31:0]            exp_crc_r,      exp_crc_nxt;
  logic [31:0]            key_len_r,      key_len_nxt;
  logic [31:0]            val_len_r,      val_len_nxt;
  logic [31:0]            left_r,         left_nxt;
  logic [31:0]            crc_r,          crc_nxt;
  logic [OFFSET_BITS-1:0] offset_r,       offset_nxt;

  logic [31:0]            crc_upd;
  logic [31:0]            left_dec;
  logic                   last_field_byte;
  logic                   finish;
  logic                   crc_match;
  logic [31:0]            close_val_len;
  logic [OFFSET_BITS:0]   rec_size;
  logic [OFFSET_BITS:0]   offset_sum;
  logic                   trunc;

  assign crc_upd         = crc32_byte(crc_r, data_byte);
  assign left_dec        = left_r - 32'd1;
  assign last_field_byte = (idx_r == 2'd3);

  // A record closing in the value-length phase always has an empty value
  assign close_val_len = (phase_r == PH_VAL) ? val_len_r : 32'd0;

  // Verdict and saturating offset advance for a closing record
  assign crc_match  = ((crc_upd ^ CRC_ONES) == exp_crc_r);
  assign rec_size   = HDR_BYTES + (OFFSET_BITS+1)'(key_len_r)
                    + (OFFSET_BITS+1)'(close_val_len);
  assign offset_sum = {1'b0, offset_r} + rec_size;

  assign trunc = (phase_r != PH_HALT) && ((phase_r != PH_CRC) || (idx_r != 2'd0));

  // Next state and result
  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    exp_crc_nxt = exp_crc_r;
    key_len_nxt = key_len_r;
    val_len_nxt = val_len_r;
    left_nxt    = left_r;
    crc_nxt     = crc_r;
    offset_nxt  = offset_r;
    finish      = 1'b0;

    result.payload_kind = KIND_NONE;
    result.payload_byte = 8'd0;

    if (cmd == CMD_BYTE) begin
      case (phase_r)
        PH_CRC: begin
          idx_nxt = idx_r + 2'd1;
          case (idx_r)
            2'd0:    exp_crc_nxt = {24'd0, data_byte};
            2'd1:    exp_crc_nxt[15:8]  = data_byte;
            2'd2:    exp_crc_nxt[23:16] = data_byte;
            default: exp_crc_nxt[31:24] = data_byte;
          endcase
          if (last_field_byte) begin
            phase_nxt = PH_KLEN;
          end
        end
        PH_KLEN: begin
          crc_nxt = crc_upd;
          idx_nxt = idx_r + 2'd1;
          case (idx_r)
            2'd0:    key_len_nxt = {24'd0, data_byte};
            2'd1:    key_len_nxt[15:8]  = data_byte;
            2'd2:    key_len_nxt[23:16] = data_byte;
            default: key_len_nxt[31:24] = data_byte;
          endcase
          if (last_field_byte) begin
            left_nxt  = key_len_nxt;
            phase_nxt = (key_len_nxt == 32'd0) ? PH_VLEN : PH_KEY;
          end
        end
        PH_KEY: begin
          crc_nxt             = crc_upd;
          result.payload_kind = KIND_KEY;
          result.payload_byte = data_byte;
          left_nxt            = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt = PH_VLEN;
          end
        end
        PH_VLEN: begin
          crc_nxt = crc_upd;
          idx_nxt = idx_r + 2'd1;
          case (idx_r)
            2'd0:    val_len_nxt = {24'd0, data_byte};
            2'd1:    val_len_nxt[15:8]  = data_byte;
            2'd2:    val_len_nxt[23:16] = data_byte;
            default: val_len_nxt[31:24] = data_byte;
          endcase
          if (last_field_byte) begin
            left_nxt = val_len_nxt;
            if (val_len_nxt == 32'd0) begin
              finish = 1'b1;
            end else begin
              phase_nxt = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          crc_nxt             = crc_upd;
          result.payload_kind = KIND_VALUE;
          result.payload_byte = data_byte;
          left_nxt            = left_dec;
          if (left_dec == 32'd0) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase

      // Close the record: advance or halt, then rearm the checksum
      if (finish) begin
        if (crc_match) begin
          phase_nxt  = PH_CRC;
          offset_nxt = offset_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}}
                                               : offset_sum[OFFSET_BITS-1:0];
        end else begin
          phase_nxt = PH_HALT;
        end
        crc_nxt  = CRC_ONES;
        idx_nxt  = 2'd0;
        left_nxt = 32'd0;
      end
    end

    result.record_end   = finish;
    result.record_ok    = finish && crc_match;
    result.key_length   = key_len_nxt;
    result.value_length = val_len_nxt;
    result.halted       = (phase_nxt == PH_HALT);
    result.log_end      = (cmd == CMD_END);
    result.truncated    = (cmd == CMD_END) && trunc;
    result.valid_offset = offset_nxt;
  end

  // Advance on each transfer; end of log returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (step && (cmd == CMD_END))) begin
      phase_r   <= PH_CRC;
      idx_r     <= 2'd0;
      exp_crc_r <= 32'd0;
      key_len_r <= 32'd0;
      val_len_r <= 32'd0;
      left_r    <= 32'd0;
      crc_r     <= CRC_ONES;
      offset_r  <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      exp_crc_r <= exp_crc_nxt;
      key_len_r <= key_len_nxt;
      val_len_r <= val_len_nxt;
      left_r    <= left_nxt;
      crc_r     <= crc_nxt;
      offset_r  <= offset_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/log_record_checker.sv =====
// Each result is registered and appears in the cycle after its input transfer.
// Throughput: one byte per cycle when not stalled; byte-wide CRC update and
// field counters finish each byte between the parse state and result register.
// Reset: synchronous active-low rst_n clears the parse state and output valid;
// an end-of-log transfer also returns the parse state to its reset values.
// ----------------------------------------------------------------------------
// log_record_checker: length-prefixed CRC-32 log record checker
// Deframes records byte by byte, tags key and value bytes, reports verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module log_record_checker
  import lrc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic                   in_cmd,
  input  wire logic [7:0]             in_data_byte,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic [1:0]             out_payload_kind,
  output      logic [7:0]             out_payload_byte,
  output      logic                   out_record_end,
  output      logic                   out_record_ok,
  output      logic [31:0]            out_key_length,
  output      logic [31:0]            out_value_length,
  output      logic                   out_halted,
  output      logic                   out_log_end,
  output      logic                   out_truncated,
  output      logic [OFFSET_BITS-1:0] out_valid_offset
);

  logic        in_xfer;
  logic        out_valid_r;
  lrc_result_t res;
  lrc_result_t res_r;

  // Accept whenever the result register is empty or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  lrc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .result    (res)
  );

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_kind = res_r.payload_kind;
  assign out_payload_byte = res_r.payload_byte;
  assign out_record_end   = res_r.record_end;
  assign out_record_ok    = res_r.record_ok;
  assign out_key_length   = res_r.key_length;
  assign out_value_length = res_r.value_length;
  assign out_halted       = res_r.halted;
  assign out_log_end      = res_r.log_end;
  assign out_truncated    = res_r.truncated;
  assign out_valid_offset = res_r.valid_offset;

endmodule

`default_nettype wire

// ===== test/tb_log_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_record_checker: self-checking bench for the log record checker
// Streams directed and random log bytes through the valid/stall input, runs a
// bit-accurate deframing and CRC-32 predictor alongside the DUT, and compares
// every result transfer field by field under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_log_record_checker;
  import lrc_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 200;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        typed;
    lrc_result_t want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = CMD_BYTE;
  logic [7:0]             in_data_byte = 8'h00;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_payload_kind;
  logic [7:0]             out_payload_byte;
  logic                   out_record_end;
  logic                   out_record_ok;
  logic [31:0]            out_key_length;
  logic [31:0]            out_value_length;
  logic                   out_halted;
  logic                   out_log_end;
  logic                   out_truncated;
  logic [OFFSET_BITS-1:0] out_valid_offset;

  // Predictor state
  logic [2:0]             rx_phase;
  logic [1:0]             byte_pos;
  logic [31:0]            hdr_sum;
  logic [31:0]            hdr_key_len;
  logic [31:0]            hdr_val_len;
  logic [31:0]            payload_left;
  logic [31:0]            crc_acc;
  logic [OFFSET_BITS-1:0] good_bytes;

  lrc_result_t expected_reports[$];
  plan_row_t   directed_plan[$];
  int          err_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  log_record_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_kind (out_payload_kind),
    .out_payload_byte (out_payload_byte),
    .out_record_end   (out_record_end),
    .out_record_ok    (out_record_ok),
    .out_key_length   (out_key_length),
    .out_value_length (out_value_length),
    .out_halted       (out_halted),
    .out_log_end      (out_log_end),
    .out_truncated    (out_truncated),
    .out_valid_offset (out_valid_offset)
  );

  // Free-running clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Reflected CRC-32, feeding data bits LSB first into the register tap
  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[k]}});
    end
    return c;
  endfunction

  // Merge one little-endian byte into a 32-bit field; byte 0 clears it
  function automatic logic [31:0] le_merge(input logic [31:0] acc, input logic [1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] base;
    base = (idx == 2'd0) ? 32'd0 : acc;
    return base | ({24'd0, b} << (8 * idx));
  endfunction

  function automatic lrc_result_t make_report(input logic [31:0] klen,
                                              input logic [31:0] vlen,
                                              input logic rend, input logic halt,
                                              input logic lend, input logic trunc,
                                              input logic [OFFSET_BITS-1:0] off);
    lrc_result_t r;
    r = '0;
    r.record_end   = rend;
    r.key_length   = klen;
    r.value_length = vlen;
    r.halted       = halt;
    r.log_end      = lend;
    r.truncated    = trunc;
    r.valid_offset = off;
    return r;
  endfunction

  // Mostly short fields, some empty, a few longer ones
  function automatic logic [31:0] pick_len();
    if ($urandom_range(99) < 25) begin
      return 32'd0;
    end
    if ($urandom_range(99) < 90) begin
      return $urandom_range(1, 6);
    end
    return $urandom_range(7, 40);
  endfunction

  task automatic parser_reset();
    rx_phase     = PH_CRC;
    byte_pos     = 2'd0;
    hdr_sum      = 32'd0;
    hdr_key_len  = 32'd0;
    hdr_val_len  = 32'd0;
    payload_left = 32'd0;
    crc_acc      = CRC_ONES;
    good_bytes   = '0;
  endtask

  // Close a record: check the sum, advance the saturating offset on success
  task automatic close_record(output logic ok);
    logic [OFFSET_BITS+1:0] total;
    ok = ((~crc_acc) == hdr_sum);
    if (ok) begin
      total = {2'b00, good_bytes} + (OFFSET_BITS+2)'(12) + (OFFSET_BITS+2)'(hdr_key_len)
              + (OFFSET_BITS+2)'(hdr_val_len);
      if (total > {2'b00, {OFFSET_BITS{1'b1}}}) begin
        good_bytes = '1;
      end else begin
        good_bytes = total[OFFSET_BITS-1:0];
      end
      rx_phase = PH_CRC;
    end else begin
      rx_phase = PH_HALT;
    end
    crc_acc      = CRC_ONES;
    byte_pos     = 2'd0;
    payload_left = 32'd0;
  endtask

  // Deframe one input item and compute the report it produces
  task automatic deframe_step(input logic c, input logic [7:0] b, output lrc_result_t r);
    logic ok;
    r = '0;
    if (c == CMD_END) begin
      r.log_end   = 1'b1;
      r.truncated = (rx_phase != PH_HALT) && (rx_phase != PH_CRC || byte_pos != 2'd0);
    end else begin
      case (rx_phase)
        PH_CRC: begin
          hdr_sum  = le_merge(hdr_sum, byte_pos, b);
          byte_pos = byte_pos + 2'd1;
          if (byte_pos == 2'd0) rx_phase = PH_KLEN;
        end
        PH_KLEN: begin
          crc_acc     = crc_fold(crc_acc, b);
          hdr_key_len = le_merge(hdr_key_len, byte_pos, b);
          byte_pos    = byte_pos + 2'd1;
          if (byte_pos == 2'd0) begin
            payload_left = hdr_key_len;
            rx_phase = (hdr_key_len == 32'd0) ? PH_VLEN : PH_KEY;
          end
        end
        PH_KEY: begin
          crc_acc        = crc_fold(crc_acc, b);
          r.payload_kind = KIND_KEY;
          r.payload_byte = b;
          payload_left   = payload_left - 32'd1;
          if (payload_left == 32'd0) rx_phase = PH_VLEN;
        end
        PH_VLEN: begin
          crc_acc     = crc_fold(crc_acc, b);
          hdr_val_len = le_merge(hdr_val_len, byte_pos, b);
          byte_pos    = byte_pos + 2'd1;
          if (byte_pos == 2'd0) begin
            payload_left = hdr_val_len;
            if (hdr_val_len == 32'd0) begin
              r.record_end = 1'b1;
              close_record(ok);
              r.record_ok = ok;
            end else begin
              rx_phase = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          crc_acc        = crc_fold(crc_acc, b);
          r.payload_kind = KIND_VALUE;
          r.payload_byte = b;
          payload_left   = payload_left - 32'd1;
          if (payload_left == 32'd0) begin
            r.record_end = 1'b1;
            close_record(ok);
            r.record_ok = ok;
          end
        end
        default: begin
          rx_phase = PH_HALT;
        end
      endcase
    end
    r.key_length   = hdr_key_len;
    r.value_length = hdr_val_len;
    r.halted       = (rx_phase == PH_HALT);
    r.valid_offset = good_bytes;
    if (c == CMD_END) parser_reset();
  endtask

  // Offer one item, hold it until the transfer, then queue its expected report
  task automatic push_item(input logic c, input logic [7:0] b, input logic use_typed,
                           input lrc_result_t typed);
    lrc_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(c, b, predicted);
    expected_reports.push_back(use_typed ? typed : predicted);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(CMD_BYTE, b, 1'b0, '0);
  endtask

  task automatic send_end();
    push_item(CMD_END, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Drop valid and wait until every expected report has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(input logic c, input logic [7:0] b, input logic typed,
                         input lrc_result_t want);
    plan_row_t row;
    row.cmd   = c;
    row.data  = b;
    row.typed = typed;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  // Send a record; cut < 0 sends it whole with a valid (or corrupted) sum,
  // otherwise only its first cut bytes go out
  task automatic send_record(input logic [31:0] klen, input logic [31:0] vlen,
                             input logic bad, input int cut);
    logic [7:0]  body[$];
    logic [31:0] acc;
    logic [31:0] sum;
    longint      kl;
    longint      n;
    int          p;
    kl = klen;
    if (cut < 0) begin
      n = 64'd8 + klen + vlen;
    end else begin
      n = (cut > 4) ? cut - 4 : 0;
    end
    for (p = 0; p < n; p++) begin
      if (p < 4) begin
        body.push_back(klen[8*p +: 8]);
      end else if (p < 4 + kl) begin
        body.push_back(8'($urandom_range(255)));
      end else if (p < 8 + kl) begin
        body.push_back(vlen[8*(p - 4 - int'(kl)) +: 8]);
      end else begin
        body.push_back(8'($urandom_range(255)));
      end
    end
    if (cut < 0) begin
      acc = CRC_ONES;
      foreach (body[i]) acc = crc_fold(acc, body[i]);
      sum = ~acc;
    end else begin
      sum = $urandom;
    end
    if (bad) sum = sum ^ (32'd1 << $urandom_range(31));
    for (p = 0; p < 4 && (cut < 0 || p < cut); p++) send_byte(sum[8*p +: 8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // One random stretch of log, always left on a record boundary or after an end
  task automatic send_segment();
    int          sel;
    int          cut;
    logic [31:0] kl;
    logic [31:0] vl;
    longint      total;
    sel = $urandom_range(99);
    if (sel < 62) begin
      send_record(pick_len(), pick_len(), 1'b0, -1);
    end else if (sel < 72) begin
      send_record(pick_len(), pick_len(), 1'b1, -1);
      repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
      send_end();
    end else if (sel < 80) begin
      send_end();
    end else if (sel < 90) begin
      kl = ($urandom_range(2) == 0) ? $urandom : pick_len();
      vl = ($urandom_range(2) == 0) ? $urandom : pick_len();
      total = 64'd12 + kl + vl;
      cut = (total > 31) ? $urandom_range(1, 30) : $urandom_range(1, int'(total) - 1);
      send_record(kl, vl, 1'b0, cut);
      send_end();
    end else begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(255)));
      send_end();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= PRINT_CAP) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each result transfer against the oldest expected report
  always @(posedge clk) begin
    lrc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        err_count++;
        if (err_count <= PRINT_CAP) begin
          $display("%0t: unexpected result transfer, expected none actual kind %0h",
                   $time, out_payload_kind);
        end
      end else begin
        want = expected_reports.pop_front();
        check_field("payload_kind", want.payload_kind, out_payload_kind);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("record_end", want.record_end, out_record_end);
        check_field("record_ok", want.record_ok, out_record_ok);
        check_field("key_length", want.key_length, out_key_length);
        check_field("value_length", want.value_length, out_value_length);
        check_field("halted", want.halted, out_halted);
        check_field("log_end", want.log_end, out_log_end);
        check_field("truncated", want.truncated, out_truncated);
        check_field("valid_offset", want.valid_offset, out_valid_offset);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0]  good_body[9];
    logic [7:0]  bad_body[13];
    logic [31:0] acc;
    logic [31:0] good_sum;
    int          base;
    parser_reset();

    // End of log straight after reset
    add_row(CMD_END, 8'h00, 1'b1, make_report(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    // Good record: empty key, one value byte; then end on the record boundary
    good_body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
    acc = CRC_ONES;
    foreach (good_body[i]) acc = crc_fold(acc, good_body[i]);
    good_sum = ~acc;
    for (int i = 0; i < 4; i++) add_row(CMD_BYTE, good_sum[8*i +: 8], 1'b0, '0);
    foreach (good_body[i]) add_row(CMD_BYTE, good_body[i], 1'b0, '0);
    add_row(CMD_END, 8'h5A, 1'b1,
            make_report(32'd0, 32'd1, 1'b0, 1'b0, 1'b1, 1'b0, OFFSET_BITS'(13)));
    // Zero checksum on a one-byte key, empty value: mismatch halts the parser
    bad_body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'hA5,
                 8'h00, 8'h00, 8'h00, 8'h00};
    for (int i = 0; i < 12; i++) add_row(CMD_BYTE, bad_body[i], 1'b0, '0);
    add_row(CMD_BYTE, bad_body[12], 1'b1,
            make_report(32'd1, 32'd0, 1'b1, 1'b1, 1'b0, 1'b0, '0));
    // Halted: byte ignored, then end of log while halted
    add_row(CMD_BYTE, 8'hFF, 1'b1, make_report(32'd1, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, '0));
    add_row(CMD_END, 8'hFF, 1'b1, make_report(32'd1, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      push_item(directed_plan[i].cmd, directed_plan[i].data, directed_plan[i].typed,
                directed_plan[i].want);
    end
    settle();

    // Random log under each idle/stall mix, draining between mixes
    base = items_sent;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      while (items_sent < base + (mode + 1) * RANDOM_ITEMS / 4) send_segment();
      settle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lrc_pkg.sv
sv/lrc_parser.sv
sv/log_record_checker.sv
test/tb_log_record_checker.sv
